// File: rtl/core/page_replacement_policy_core_defines.svh
// Assertion macros for the page replacement core checker.
// Expects clk and rst_n in the scope of each use.
`ifndef PAGE_REPLACEMENT_POLICY_CORE_DEFINES_SVH
`define PAGE_REPLACEMENT_POLICY_CORE_DEFINES_SVH

// same-cycle implication
`define PRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page replacement check failed");

// next-cycle implication
`define PRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page replacement check failed");

`endif

// File: rtl/core/prp_pkg.sv
// Shared types and constants for the page replacement core.
// No dependencies.
package prp_pkg;

  localparam int MAX_FRAMES  = 32;
  localparam int PAGE_W      = 6;
  localparam int SLOT_W      = 5;
  localparam int RANK_W      = 5;
  localparam int CNT_W       = 6;
  localparam int FAULT_W     = 32;
  localparam int GRP_SIZE    = 8;
  localparam int GRP_NUM     = MAX_FRAMES / GRP_SIZE;
  localparam int GRP_IDX_W   = 3;
  localparam int GRP_SEL_W   = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USER_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY      = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    POL_FIFO = 1'b0,
    POL_LRU  = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOOK = 2'd1,
    ST_UPD  = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

// File: rtl/core/prp_ctrl.sv
// Controller state machine for the page replacement core.
// Depends on prp_pkg.
module prp_ctrl
  import prp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   out_free;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    out_free    = !out_vld_r || out_tready;
    in_tready   = 1'b0;
    cmd         = '0;
    state_nxt   = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.capture = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          in_tready  = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = in_tvalid ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    accept   = in_tvalid && in_tready;
    cmd.load = accept;
    if (cmd.commit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

// File: rtl/core/prp_dpath.sv
// Datapath for the page replacement core: frame tags, recency ranks,
// FIFO pointer, fault counter, configuration and result registers. Depends on prp_pkg.
module prp_dpath
  import prp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [PAGE_W-1:0]     in_page,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  res_hit,
  output logic [SLOT_W-1:0]     res_slot,
  output logic                  res_ev_valid,
  output logic [PAGE_W-1:0]     res_ev_page,
  output logic [FAULT_W-1:0]    res_fault
);

  logic                 policy_r;
  logic [CNT_W-1:0]     fcount_r;
  logic [PAGE_W-1:0]    page_r;
  logic [PAGE_W-1:0]    frame_page_r [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_r       [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_nxt     [MAX_FRAMES];
  logic [CNT_W-1:0]     fiu_r, fiu_nxt;
  logic [SLOT_W-1:0]    fifo_ptr_r, fifo_ptr_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;

  logic                 hit_r;
  logic [SLOT_W-1:0]    hit_idx_r;
  logic [RANK_W-1:0]    hit_rank_r;
  logic [RANK_W-1:0]    gmax_r [GRP_NUM];
  logic [GRP_IDX_W-1:0] gidx_r [GRP_NUM];
  logic [GRP_NUM-1:0]   gvld_r;

  logic                 hit_c;
  logic [SLOT_W-1:0]    hit_idx_c;
  logic [RANK_W-1:0]    gmax_c [GRP_NUM];
  logic [GRP_IDX_W-1:0] gidx_c [GRP_NUM];
  logic [GRP_NUM-1:0]   gvld_c;

  logic [CNT_W-1:0]     eff;
  logic [CNT_W-1:0]     active;
  logic                 fill;
  logic [SLOT_W-1:0]    ptr_use;
  logic [CNT_W-1:0]     ptr_inc;
  logic [RANK_W-1:0]    vmax;
  logic [SLOT_W-1:0]    vslot;
  logic [SLOT_W-1:0]    slot;
  logic [RANK_W-1:0]    ref_rank;
  logic [CNT_W-1:0]     span;
  logic                 fresh;
  logic                 ev_valid;
  logic [PAGE_W-1:0]    ev_page;

  always_comb begin
    if (fcount_r == '0) begin
      eff = CNT_W'(1);
    end else if (fcount_r > CNT_W'(MAX_FRAMES)) begin
      eff = CNT_W'(MAX_FRAMES);
    end else begin
      eff = fcount_r;
    end
    active = (fiu_r < eff) ? fiu_r : eff;
  end

  // lookup: tag compare and per-group oldest frame
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < active) && (frame_page_r[i] == page_r)) begin
        hit_c     = 1'b1;
        hit_idx_c = SLOT_W'(i);
      end
    end
    for (int g = 0; g < GRP_NUM; g++) begin
      gmax_c[g] = rank_r[g*GRP_SIZE];
      gidx_c[g] = '0;
      gvld_c[g] = CNT_W'(g*GRP_SIZE) < eff;
      for (int k = 1; k < GRP_SIZE; k++) begin
        if ((CNT_W'(g*GRP_SIZE + k) < eff) && (rank_r[g*GRP_SIZE + k] > gmax_c[g])) begin
          gmax_c[g] = rank_r[g*GRP_SIZE + k];
          gidx_c[g] = GRP_IDX_W'(k);
        end
      end
    end
  end

  // update: pick slot, ranks, pointer, counter
  always_comb begin
    vmax  = gmax_r[0];
    vslot = {GRP_SEL_W'(0), gidx_r[0]};
    for (int g = 1; g < GRP_NUM; g++) begin
      if (gvld_r[g] && (gmax_r[g] > vmax)) begin
        vmax  = gmax_r[g];
        vslot = {GRP_SEL_W'(g), gidx_r[g]};
      end
    end

    ptr_use = ({1'b0, fifo_ptr_r} >= eff) ? '0 : fifo_ptr_r;
    ptr_inc = {1'b0, ptr_use} + CNT_W'(1);
    fill    = fiu_r < eff;

    fiu_nxt      = fiu_r;
    fifo_ptr_nxt = fifo_ptr_r;
    fault_nxt    = fault_r;
    ev_valid     = 1'b0;
    fresh        = 1'b0;

    if (hit_r) begin
      slot     = hit_idx_r;
      ref_rank = hit_rank_r;
      span     = active;
    end else if (fill) begin
      slot     = fiu_r[SLOT_W-1:0];
      ref_rank = '0;
      span     = fiu_r + CNT_W'(1);
      fresh    = 1'b1;
      fiu_nxt  = fiu_r + CNT_W'(1);
    end else begin
      ev_valid = 1'b1;
      span     = eff;
      if (policy_r == POL_FIFO) begin
        slot         = ptr_use;
        ref_rank     = rank_r[ptr_use];
        fifo_ptr_nxt = (ptr_inc >= eff) ? '0 : ptr_inc[SLOT_W-1:0];
      end else begin
        slot     = vslot;
        ref_rank = vmax;
      end
    end
    if (!hit_r && (fault_r != '1)) fault_nxt = fault_r + FAULT_W'(1);
    ev_page = ev_valid ? frame_page_r[slot] : '0;

    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (SLOT_W'(i) == slot) begin
        rank_nxt[i] = '0;
      end else if ((CNT_W'(i) < span) && (fresh || (rank_r[i] < ref_rank))) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= POL_FIFO;
      fcount_r   <= CNT_W'(4);
      fiu_r      <= '0;
      fifo_ptr_r <= '0;
      fault_r    <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) rank_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_POLICY:      policy_r <= cfg_wdata[0];
          REG_FRAME_COUNT: fcount_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        fiu_r      <= fiu_nxt;
        fifo_ptr_r <= fifo_ptr_nxt;
        fault_r    <= fault_nxt;
        for (int i = 0; i < MAX_FRAMES; i++) rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) page_r <= in_page;
    if (cmd.capture) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      hit_rank_r <= rank_r[hit_idx_c];
      gmax_r     <= gmax_c;
      gidx_r     <= gidx_c;
      gvld_r     <= gvld_c;
    end
    if (cmd.commit) begin
      if (!hit_r) frame_page_r[slot] <= page_r;
      res_hit      <= hit_r;
      res_slot     <= slot;
      res_ev_valid <= ev_valid;
      res_ev_page  <= ev_page;
      res_fault    <= fault_nxt;
    end
  end

endmodule

// File: rtl/core/page_replacement_policy_core.sv
// Top level of the FIFO/LRU page replacement core.
// Depends on prp_pkg, prp_ctrl and prp_dpath.
//
//  channel | dir | word
//  in_     | in  | tdata[5:0] page_number
//  out_    | out | tdata: slot, evicted_page, fault_count; tuser: hit, evicted_valid
//  cfg_    | in  | cfg_index selects policy or frame_count, cfg_data value
//
// Each reference passes through a tag compare and per-group rank search,
// then the rank, pointer and counter update.
// The next word is taken in the update cycle when the output register is free.
// A stalled output holds the update cycle and the input.
// Reset is synchronous; frame tags are not cleared, ranks and counters are.
module page_replacement_policy_core
  import prp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [5:0] page_number
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] slot, [10:5] evicted_page, [42:11] fault_count
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] hit, [1] evicted_valid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t              cmd;
  logic                 res_hit;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_ev_valid;
  logic [PAGE_W-1:0]    res_ev_page;
  logic [FAULT_W-1:0]   res_fault;

  assign cfg_ready = 1'b1;

  prp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  prp_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_page      (in_tdata[PAGE_W-1:0]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_reg_t'(cfg_index)),
    .cfg_wdata    (cfg_data),
    .res_hit      (res_hit),
    .res_slot     (res_slot),
    .res_ev_valid (res_ev_valid),
    .res_ev_page  (res_ev_page),
    .res_fault    (res_fault)
  );

  assign out_tdata = {(OUT_DATA_W - SLOT_W - PAGE_W - FAULT_W)'(0),
                      res_fault, res_ev_page, res_slot};
  assign out_tuser = {res_ev_valid, res_hit};

endmodule

// File: rtl/core/prp_checker.sv
// Port-level checker for the page replacement core, bound to the top level.
// Depends on prp_pkg and page_replacement_policy_core_defines.svh.
`include "page_replacement_policy_core_defines.svh"

module prp_checker
  import prp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  `PRP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `PRP_ASSERT_NEXT(a_lookup_busy, in_tvalid && in_tready, !in_tready)
  `PRP_ASSERT_NOW(a_hit_no_evict, out_tvalid && out_tuser[0], !out_tuser[1])
  `PRP_ASSERT_NOW(a_no_evict_zero, out_tvalid && !out_tuser[1], out_tdata[10:5] == 6'd0)

endmodule

bind page_replacement_policy_core prp_checker u_prp_checker (.*);
